// ----- rtl/csb_pkg.sv -----
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants for the per-channel scale and bias block.
// ----------------------------------------------------------------------------
package csb_pkg;

	localparam int MAX_CHANNELS = 1024;
	localparam int CH_W         = $clog2(MAX_CHANNELS);
	localparam int DATA_W       = 16;
	localparam int CFG_W        = 17;
	localparam int CFG_IDX_W    = 2;
	localparam int POS_W        = 16;
	localparam int CH_CNT_W     = 11;

	typedef enum logic [1:0] {
		OP_LOAD_SCALE = 2'd0,
		OP_LOAD_BIAS  = 2'd1,
		OP_SAMPLE     = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER_SIZE    = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_OUTER_COUNT   = 2'd2,
		REG_BIAS_ENABLE   = 2'd3
	} reg_idx_t;

	localparam logic signed [DATA_W-1:0] RESULT_MAX = 16'sh7fff;
	localparam logic signed [DATA_W-1:0] RESULT_MIN = 16'sh8000;

endpackage

// ----- rtl/channel_scale_bias.sv -----
// ----------------------------------------------------------------------------
// channel_scale_bias
// Per-channel scale and bias over a streamed tensor, Q8.8 data, Q4.12 scale.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (item_valid / item_stall) carries one word per cycle
// while item_stall is low: a scale load, a bias load or a data sample. Loads
// write the scale or bias memory at the given index and give no result.
// Every channel entry must be loaded before a sample of that channel arrives.
// Each sample gives one word on the result channel (result_valid /
// result_stall): the rounded product with scale, plus bias if enabled,
// saturated to 16 bits, with its channel and a flag on the tensor's last
// sample. A sample's result passes the table read, product and output registers.
// Throughput is one word per cycle while the receiver does not stall; the three
// stages (memory read, multiply, round/bias/saturate) each hold one word and
// advance independently, so bubbles are squeezed out while the receiver stalls.
// item_stall rises only when all three stages are full and the output word is stalled.
// Reset clears the pipeline and the position counters and sets the shape
// to one sample; the tables keep no defined content. Any register write
// restarts the tensor at position zero.
// ----------------------------------------------------------------------------
module channel_scale_bias import csb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	// input channel
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [1:0]               operation,
	input  logic [CH_W-1:0]          index,
	input  logic signed [DATA_W-1:0] value,
	// result channel
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [DATA_W-1:0] result,
	output logic [CH_W-1:0]          channel,
	output logic                     saturated,
	output logic                     last
);

	function automatic logic [POS_W-1:0] count_to_last16(input logic [CFG_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v[CFG_W-1]) begin
			r = '1;
		end else begin
			r = v[POS_W-1:0] - 1'b1;
		end
		return r;
	endfunction

	function automatic logic [CH_W-1:0] count_to_last_ch(input logic [CH_CNT_W-1:0] v);
		logic [CH_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v[CH_CNT_W-1]) begin
			r = '1;
		end else begin
			r = v[CH_W-1:0] - 1'b1;
		end
		return r;
	endfunction

	// Configuration, held as the last position of each counter.
	logic [POS_W-1:0] inner_last_q;
	logic [CH_W-1:0]  chan_last_q;
	logic [POS_W-1:0] outer_last_q;
	logic             bias_en_q;

	// Position counters.
	logic [POS_W-1:0] inner_pos_q;
	logic [CH_W-1:0]  chan_pos_q;
	logic [POS_W-1:0] outer_pos_q;

	// Channel tables.
	logic [DATA_W-1:0] scale_mem [MAX_CHANNELS];
	logic [DATA_W-1:0] bias_mem  [MAX_CHANNELS];

	// Stage 1: table read.
	logic                     v_s1;
	logic signed [DATA_W-1:0] sample_s1;
	logic [CH_W-1:0]          ch_s1;
	logic                     last_s1;
	logic signed [DATA_W-1:0] scale_s1;
	logic signed [DATA_W-1:0] bias_s1;

	// Stage 2: product.
	logic                       v_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic signed [DATA_W-1:0]   bias_s2;
	logic [CH_W-1:0]            ch_s2;
	logic                       last_s2;

	// Output register.
	logic                     out_v_q;
	logic signed [DATA_W-1:0] result_q;
	logic [CH_W-1:0]          chan_q;
	logic                     sat_q;
	logic                     last_q;

	logic en_out, en2, en1;
	logic accept, is_sample, is_scale, is_bias;
	logic end_in, end_ch, end_out;

	logic signed [2*DATA_W:0]   rnd_sum;
	logic signed [20:0]         rnd_q88;
	logic signed [21:0]         acc;
	logic signed [DATA_W-1:0]   sat_val;
	logic                       sat_flag;

	assign en_out = !out_v_q || !result_stall;
	assign en2    = !v_s2 || en_out;
	assign en1    = !v_s1 || en2;

	assign item_stall = !en1;
	assign accept     = item_valid && en1;
	assign is_sample  = accept && (op_t'(operation) == OP_SAMPLE);
	assign is_scale   = accept && (op_t'(operation) == OP_LOAD_SCALE);
	assign is_bias    = accept && (op_t'(operation) == OP_LOAD_BIAS);

	assign end_in  = (inner_pos_q == inner_last_q);
	assign end_ch  = (chan_pos_q == chan_last_q);
	assign end_out = (outer_pos_q == outer_last_q);

	// Configuration and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_last_q <= '0;
			chan_last_q  <= '0;
			outer_last_q <= '0;
			bias_en_q    <= 1'b0;
			inner_pos_q  <= '0;
			chan_pos_q   <= '0;
			outer_pos_q  <= '0;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_INNER_SIZE:    inner_last_q <= count_to_last16(cfg_data);
				REG_CHANNEL_COUNT: chan_last_q  <= count_to_last_ch(cfg_data[CH_CNT_W-1:0]);
				REG_OUTER_COUNT:   outer_last_q <= count_to_last16(cfg_data);
				REG_BIAS_ENABLE:   bias_en_q    <= cfg_data[0];
				default:           bias_en_q    <= bias_en_q;
			endcase
			inner_pos_q <= '0;
			chan_pos_q  <= '0;
			outer_pos_q <= '0;
		end else if (is_sample) begin
			if (!end_in) begin
				inner_pos_q <= inner_pos_q + 1'b1;
			end else begin
				inner_pos_q <= '0;
				if (!end_ch) begin
					chan_pos_q <= chan_pos_q + 1'b1;
				end else begin
					chan_pos_q <= '0;
					outer_pos_q <= end_out ? '0 : outer_pos_q + 1'b1;
				end
			end
		end
	end

	// Table memories: loads write at acceptance, the sample's channel is read
	// at its own acceptance edge, so a load is always visible to later samples.
	always_ff @(posedge clk) begin
		if (is_scale) begin
			scale_mem[index] <= value;
		end
		if (is_bias) begin
			bias_mem[index] <= value;
		end
		if (en1) begin
			scale_s1 <= scale_mem[chan_pos_q];
			bias_s1  <= bias_mem[chan_pos_q];
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= is_sample;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (en1) begin
			sample_s1 <= value;
			ch_s1     <= chan_pos_q;
			last_s1   <= end_in && end_ch && end_out;
		end
		if (en2) begin
			prod_s2 <= sample_s1 * scale_s1;
			bias_s2 <= bias_s1;
			ch_s2   <= ch_s1;
			last_s2 <= last_s1;
		end
		if (en_out) begin
			result_q <= sat_val;
			chan_q   <= ch_s2;
			sat_q    <= sat_flag;
			last_q   <= last_s2;
		end
	end

	// Round Q12.20 to Q8.8 (ties toward plus infinity), add bias, saturate.
	always_comb begin
		rnd_sum  = $signed({prod_s2[2*DATA_W-1], prod_s2}) + 33'sd2048;
		rnd_q88  = rnd_sum[32:12];
		acc      = $signed({rnd_q88[20], rnd_q88});
		if (bias_en_q) begin
			acc = acc + $signed({{6{bias_s2[DATA_W-1]}}, bias_s2});
		end
		sat_flag = 1'b0;
		sat_val  = acc[DATA_W-1:0];
		if (acc > 22'sd32767) begin
			sat_val  = RESULT_MAX;
			sat_flag = 1'b1;
		end else if (acc < -22'sd32768) begin
			sat_val  = RESULT_MIN;
			sat_flag = 1'b1;
		end
	end

	assign result_valid = out_v_q;
	assign result       = result_q;
	assign channel      = chan_q;
	assign saturated    = sat_q;
	assign last         = last_q;

endmodule

// ----- rtl/csb_checker.sv -----
// ----------------------------------------------------------------------------
// csb_checker
// Port-level checks for the per-channel scale and bias block.
// ----------------------------------------------------------------------------
module csb_checker import csb_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cfg_write,
	input logic [CFG_IDX_W-1:0]     cfg_index,
	input logic [CFG_W-1:0]         cfg_data,
	input logic                     item_valid,
	input logic                     item_stall,
	input logic [1:0]               operation,
	input logic [CH_W-1:0]          index,
	input logic signed [DATA_W-1:0] value,
	input logic                     result_valid,
	input logic                     result_stall,
	input logic signed [DATA_W-1:0] result,
	input logic [CH_W-1:0]          channel,
	input logic                     saturated,
	input logic                     last
);

	// A stalled result word stays on the port.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result) && $stable(channel)
			&& $stable(saturated) && $stable(last))
		else $error("stalled result word changed");

	// A clipped result sits exactly at one of the two limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> (result == RESULT_MAX) || (result == RESULT_MIN))
		else $error("saturated flag on a value that is not a limit");

	// With the output register empty, the pipeline always has room.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("input stalled while result channel is empty");

endmodule

bind channel_scale_bias csb_checker u_csb_checker (.*);
